// ===== sv/assert_macros.svh =====
// Assertion macros used by the formatter RTL.
// Depends on nothing; taken in by `include where checks are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/sdf_pkg.sv =====
// Package for the signed decimal formatter: payload structs, sizes, char codes.
// Used by sdf_bcd and signed_decimal_formatter_unit.
`timescale 1ns / 1ps
package sdf_pkg;

  localparam int VALUE_W           = 64;
  localparam int DIGIT_SLOTS       = 20;
  localparam int DEFAULT_MAX_FIELD = 64;
  localparam int BCD_W             = DIGIT_SLOTS * 4;
  localparam int STEPS_PER_CYCLE   = 4;
  localparam int CNT_W             = $clog2(VALUE_W / STEPS_PER_CYCLE);
  localparam int ND_W              = $clog2(DIGIT_SLOTS + 1);
  localparam int DIGIT_IDX_W       = $clog2(DIGIT_SLOTS);

  // argument width codes
  localparam logic [1:0] MODE_8  = 2'd0;
  localparam logic [1:0] MODE_16 = 2'd1;
  localparam logic [1:0] MODE_32 = 2'd2;
  localparam logic [1:0] MODE_64 = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;

  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0]         mode;
    logic               has_precision;
    logic [5:0]         precision;
    logic               has_width;
    logic [6:0]         min_width;
    logic               plus_flag;
    logic               space_flag;
    logic               zero_flag;
    logic               left_flag;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        last;
    logic [31:0] total_count;
  } out_t;

endpackage

// ===== sv/sdf_bcd.sv =====
// Iterative binary-to-BCD converter (shift and add-3), four bits per cycle.
// Depends on sdf_pkg for sizes and argument width codes.
`timescale 1ns / 1ps
module sdf_bcd import sdf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] mag,
  input  logic [1:0]         mode,
  output logic               busy,
  output logic               done,
  output logic [BCD_W-1:0]   digits
);

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] bin_next;
  logic [BCD_W-1:0]   bcd_next;

  // four dependent shift steps; the add-3 per digit is independent
  always_comb begin
    bin_next = bin;
    bcd_next = bcd;
    for (int k = 0; k < STEPS_PER_CYCLE; k++) begin
      for (int d = 0; d < DIGIT_SLOTS; d++) begin
        if (bcd_next[d*4 +: 4] >= 4'd5) begin
          bcd_next[d*4 +: 4] = bcd_next[d*4 +: 4] + 4'd3;
        end
      end
      bcd_next = {bcd_next[BCD_W-2:0], bin_next[VALUE_W-1]};
      bin_next = {bin_next[VALUE_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        bcd  <= '0;
        // left-align the used bits so only the selected width is shifted
        case (mode)
          MODE_8: begin
            bin <= mag << (VALUE_W - 8);
            cnt <= CNT_W'(8 / STEPS_PER_CYCLE - 1);
          end
          MODE_16: begin
            bin <= mag << (VALUE_W - 16);
            cnt <= CNT_W'(16 / STEPS_PER_CYCLE - 1);
          end
          MODE_32: begin
            bin <= mag << (VALUE_W - 32);
            cnt <= CNT_W'(32 / STEPS_PER_CYCLE - 1);
          end
          default: begin
            bin <= mag;
            cnt <= CNT_W'(VALUE_W / STEPS_PER_CYCLE - 1);
          end
        endcase
      end else if (busy) begin
        bin <= bin_next;
        bcd <= bcd_next;
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign digits = bcd;

endmodule

// ===== sv/signed_decimal_formatter_unit.sv =====
// Signed decimal formatter: %d conversion emitted one character per output beat.
// Depends on sdf_pkg, sdf_bcd and assert_macros.svh.
//
// Input channel (in_valid/in_ready/in_item) takes one argument with its
// conversion settings. Output channel (out_valid/out_ready/out_item) gives the
// formatted text, one character per beat, last set on the final character and
// total_count carrying the running character count (wraps at 2^32).
// One conversion at a time: in_ready is high only while the sequencer is idle.
// From accept to first character the sequencer steps through prep, conversion
// of the 8/16/32/64-bit argument (the shift-and-add-3 unit, four bits a cycle,
// then its done), count and plan, and the output register. Then one character
// per cycle while out_ready does not stall, 1 to MAX_FIELD characters.
// The last beat sits in the output register and does not block the next
// accept; a stall on out_ready holds the sequencer until the register frees.
// Reset (rst, synchronous) clears the sequencer, the output valid and the
// running character count.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module signed_decimal_formatter_unit import sdf_pkg::*; #(
  parameter int MAX_FIELD = DEFAULT_MAX_FIELD
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_item,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_item
);

  localparam int CW = $clog2(MAX_FIELD + 1);

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_CONV, S_COUNT, S_PLAN, S_EMIT} state_t;

  state_t          state;
  in_t             item;
  logic            neg;
  logic [ND_W-1:0] nd;
  logic [ND_W-1:0] dig_left;
  logic [CW-1:0]   pad_pre;
  logic [CW-1:0]   pad_post;
  logic [CW-1:0]   zeros;
  logic            sign_n;
  logic [CW-1:0]   remaining;
  logic [31:0]     char_count;

  logic [VALUE_W-1:0] sx;
  logic [VALUE_W-1:0] mag;
  logic               bcd_start;
  logic               bcd_busy;
  logic               bcd_done;
  logic [BCD_W-1:0]   digits;

  // sign extension and magnitude of the stored argument
  always_comb begin
    case (item.mode)
      MODE_8:  sx = {{(VALUE_W-8){item.value[7]}}, item.value[7:0]};
      MODE_16: sx = {{(VALUE_W-16){item.value[15]}}, item.value[15:0]};
      MODE_32: sx = {{(VALUE_W-32){item.value[31]}}, item.value[31:0]};
      default: sx = item.value;
    endcase
    mag = sx[VALUE_W-1] ? (~sx + VALUE_W'(1)) : sx;
  end

  assign bcd_start = (state == S_PREP);

  sdf_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (bcd_start),
    .mag    (mag),
    .mode   (item.mode),
    .busy   (bcd_busy),
    .done   (bcd_done),
    .digits (digits)
  );

  // significant digit count, at least one
  logic [ND_W-1:0] nd_calc;
  always_comb begin
    nd_calc = ND_W'(1);
    for (int d = 0; d < DIGIT_SLOTS; d++) begin
      if (digits[d*4 +: 4] != 4'd0) nd_calc = ND_W'(d + 1);
    end
  end

  // field plan
  logic [CW-1:0] fw_c, prec_c, nd_w, zeros0, body, zeros_p, pad_p, sign_w;
  logic          sign_c;
  always_comb begin
    fw_c   = (int'(item.min_width) > MAX_FIELD) ? CW'(MAX_FIELD) : CW'(item.min_width);
    prec_c = (int'(item.precision) > MAX_FIELD - 1) ? CW'(MAX_FIELD - 1)
                                                    : CW'(item.precision);
    nd_w   = CW'(nd);
    sign_c = neg | item.plus_flag | item.space_flag;
    sign_w = CW'(sign_c);
    zeros0 = (item.has_precision && prec_c > nd_w) ? prec_c - nd_w : '0;
    body   = nd_w + zeros0 + sign_w;
    zeros_p = zeros0;
    pad_p   = '0;
    if (item.has_width && fw_c > body) begin
      if (item.zero_flag) zeros_p = fw_c - (nd_w + sign_w);
      else                pad_p   = fw_c - body;
    end
  end

  // character for this beat, by part in order
  logic       slot_free;
  logic [7:0] ch;
  logic [DIGIT_IDX_W-1:0] dig_idx;
  assign slot_free = !out_valid || out_ready;
  assign dig_idx   = DIGIT_IDX_W'(dig_left - ND_W'(1));

  always_comb begin
    if (pad_pre != '0) begin
      ch = CH_SPACE;
    end else if (sign_n) begin
      ch = neg ? CH_MINUS : (item.plus_flag ? CH_PLUS : CH_SPACE);
    end else if (zeros != '0) begin
      ch = CH_ZERO;
    end else if (dig_left != '0) begin
      ch = CH_ZERO + {4'd0, digits[dig_idx*4 +: 4]};
    end else begin
      ch = CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      char_count <= '0;
    end else begin
      // while emitting, the emit arm owns out_valid
      if (out_ready && state != S_EMIT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_item;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          neg   <= sx[VALUE_W-1];
          state <= S_CONV;
        end
        S_CONV: begin
          if (bcd_done) state <= S_COUNT;
        end
        S_COUNT: begin
          nd    <= nd_calc;
          state <= S_PLAN;
        end
        S_PLAN: begin
          dig_left  <= nd;
          sign_n    <= sign_c;
          zeros     <= zeros_p;
          pad_pre   <= (item.left_flag && item.has_width) ? '0 : pad_p;
          pad_post  <= (item.left_flag && item.has_width) ? pad_p : '0;
          remaining <= pad_p + zeros_p + sign_w + nd_w;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid            <= 1'b1;
            out_item.out_char    <= ch;
            out_item.last        <= (remaining == CW'(1));
            out_item.total_count <= char_count + 32'd1;
            char_count           <= char_count + 32'd1;
            remaining            <= remaining - CW'(1);
            if (pad_pre != '0)       pad_pre  <= pad_pre - CW'(1);
            else if (sign_n)         sign_n   <= 1'b0;
            else if (zeros != '0)    zeros    <= zeros - CW'(1);
            else if (dig_left != '0) dig_left <= dig_left - ND_W'(1);
            else                     pad_post <= pad_post - CW'(1);
            if (remaining == CW'(1)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  // converter runs only between prep and count
  `ASSERT_SAME(a_bcd_in_conv, clk, rst, bcd_busy, state == S_CONV)
  // an accepted item makes the block busy in the next cycle
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  // while idle, any waiting beat is the final one of the previous conversion
  `ASSERT_SAME(a_idle_last, clk, rst, in_ready && out_valid, out_item.last)
  // consecutive beats count up by one
  `ASSERT_NEXT(a_count_step, clk, rst, out_valid && out_ready, !out_valid || out_item.total_count == $past(out_item.total_count) + 32'd1)

endmodule

// ===== tb/tb_signed_decimal_formatter_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for signed_decimal_formatter_unit: directed and random %d conversions.
// Depends on sdf_pkg and the formatter RTL; predicts every character beat and its count.
module tb_signed_decimal_formatter_unit;
  import sdf_pkg::*;

  localparam int FIELD_CAP     = DEFAULT_MAX_FIELD;
  localparam int SETTLE_CYCLES = 60;

  // flag nibble for make_conv: {plus, space, zero, left}
  localparam logic [3:0] F_NONE  = 4'b0000;
  localparam logic [3:0] F_PLUS  = 4'b1000;
  localparam logic [3:0] F_SPACE = 4'b0100;
  localparam logic [3:0] F_ZERO  = 4'b0010;
  localparam logic [3:0] F_LEFT  = 4'b0001;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_item;

  out_t        expected_chars[$];
  logic [31:0] chars_model = '0;
  int          error_count = 0;
  int          convs_sent = 0;
  int          chars_checked = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  signed_decimal_formatter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("timeout at %0t, %0d characters still pending", $time, expected_chars.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Text the formatter should produce for one conversion, appended to expected_chars.
  task automatic format_decimal(input in_t it);
    logic [63:0] v;
    logic [63:0] mag;
    logic [3:0]  digs [DIGIT_SLOTS];
    logic [7:0]  text [$];
    logic [7:0]  sign_ch;
    int          nd;
    int          fw;
    int          prec;
    int          zeros;
    int          pad;
    int          sign_n;
    out_t        beat;
    case (it.mode)
      MODE_8:  v = {{56{it.value[7]}}, it.value[7:0]};
      MODE_16: v = {{48{it.value[15]}}, it.value[15:0]};
      MODE_32: v = {{32{it.value[31]}}, it.value[31:0]};
      default: v = it.value;
    endcase
    mag = v[63] ? (~v + 64'd1) : v;
    nd = 0;
    do begin
      if (nd < DIGIT_SLOTS) begin
        digs[nd] = 4'(mag % 64'd10);
        nd++;
      end
      mag = mag / 64'd10;
    end while (mag != 0);

    fw = int'(it.min_width);
    if (fw > FIELD_CAP) fw = FIELD_CAP;
    prec = int'(it.precision);
    if (prec > FIELD_CAP - 1) prec = FIELD_CAP - 1;
    zeros = (it.has_precision && nd < prec) ? prec - nd : 0;

    sign_n = 1;
    sign_ch = CH_SPACE;
    if (v[63]) sign_ch = CH_MINUS;
    else if (it.plus_flag) sign_ch = CH_PLUS;
    else if (it.space_flag) sign_ch = CH_SPACE;
    else sign_n = 0;

    // zero fill takes over the width entirely, precision or not
    pad = 0;
    if (it.has_width && fw > nd + zeros + sign_n) begin
      if (it.zero_flag) zeros = fw - (nd + sign_n);
      else pad = fw - (nd + zeros + sign_n);
    end

    if (!it.left_flag) repeat (pad) text.push_back(CH_SPACE);
    if (sign_n != 0) text.push_back(sign_ch);
    repeat (zeros) text.push_back(CH_ZERO);
    for (int i = nd - 1; i >= 0; i--) text.push_back(8'(CH_ZERO + digs[i]));
    if (it.left_flag) repeat (pad) text.push_back(CH_SPACE);

    foreach (text[i]) begin
      chars_model = chars_model + 32'd1;
      beat.out_char = text[i];
      beat.last = (i == text.size() - 1);
      beat.total_count = chars_model;
      expected_chars.push_back(beat);
    end
  endtask

  // Output beat checker.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t unexpected beat: char %h last %b count %0d", $time,
                 out_item.out_char, out_item.last, out_item.total_count);
        error_count++;
      end else begin
        if (out_item.out_char !== expected_chars[0].out_char) begin
          $display("%0t out_char mismatch: expected %h actual %h", $time,
                   expected_chars[0].out_char, out_item.out_char);
          error_count++;
        end
        if (out_item.last !== expected_chars[0].last) begin
          $display("%0t last mismatch: expected %b actual %b", $time,
                   expected_chars[0].last, out_item.last);
          error_count++;
        end
        if (out_item.total_count !== expected_chars[0].total_count) begin
          $display("%0t total_count mismatch: expected %0d actual %0d", $time,
                   expected_chars[0].total_count, out_item.total_count);
          error_count++;
        end
        void'(expected_chars.pop_front());
        chars_checked++;
      end
    end
  end

  function automatic in_t make_conv(logic [63:0] value, logic [1:0] mode, logic prec_on,
                                    logic [5:0] prec, logic width_on, logic [6:0] width,
                                    logic [3:0] flags);
    in_t it;
    it.value         = value;
    it.mode          = mode;
    it.has_precision = prec_on;
    it.precision     = prec;
    it.has_width     = width_on;
    it.min_width     = width;
    {it.plus_flag, it.space_flag, it.zero_flag, it.left_flag} = flags;
    return it;
  endfunction

  function automatic in_t random_conv();
    in_t         it;
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = 64'($urandom_range(20));
      1: v = -64'($urandom_range(20));
      2: v = v >> $urandom_range(63);
      3: v = -(v >> $urandom_range(63));
      4: case ($urandom_range(3))
           0: v = 64'h8000_0000_0000_0000 >> (56 - 8 * $urandom_range(7));
           1: v = 64'h7fff_ffff_ffff_ffff >> (56 - 8 * $urandom_range(7));
           2: v = '1;
           default: v = '0;
         endcase
      default: ;
    endcase
    it.value         = v;
    it.mode          = 2'($urandom_range(3));
    it.has_precision = 1'($urandom_range(1));
    // mostly short fields; now and then the widest ones
    it.precision     = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(22));
    it.has_width     = 1'($urandom_range(1));
    it.min_width     = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                                : 7'($urandom_range(26));
    it.plus_flag     = 1'($urandom_range(1));
    it.space_flag    = 1'($urandom_range(1));
    it.zero_flag     = 1'($urandom_range(1));
    it.left_flag     = 1'($urandom_range(1));
    return it;
  endfunction

  // One input beat; valid stays up until accepted.
  task automatic send_conversion(input in_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = it;
    do @(posedge clk); while (!in_ready);
    format_decimal(it);
    convs_sent++;
  endtask

  task automatic wait_text_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic do_reset();
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  endtask

  task automatic test_directed();
    send_conversion(make_conv(64'd0, MODE_64, 1'b0, 6'd0, 1'b0, 7'd0, F_NONE));
    send_conversion(make_conv(64'd0, MODE_64, 1'b1, 6'd0, 1'b0, 7'd0, F_NONE));
    send_conversion(make_conv(64'h8000_0000_0000_0000, MODE_64, 1'b0, 6'd0, 1'b0, 7'd0,
                              F_NONE));
    send_conversion(make_conv(64'h7fff_ffff_ffff_ffff, MODE_64, 1'b0, 6'd0, 1'b0, 7'd0,
                              F_PLUS));
    send_conversion(make_conv(64'hffff_ffff_ffff_ffff, MODE_64, 1'b0, 6'd0, 1'b0, 7'd0,
                              F_NONE));
    // upper bits above the selected width must be ignored
    send_conversion(make_conv(64'hdead_beef_0000_0080, MODE_8, 1'b0, 6'd0, 1'b0, 7'd0,
                              F_NONE));
    send_conversion(make_conv(64'hffff_ffff_ffff_ff7f, MODE_8, 1'b0, 6'd0, 1'b0, 7'd0,
                              F_NONE));
    send_conversion(make_conv(64'h1234_5678_9abc_8000, MODE_16, 1'b0, 6'd0, 1'b0, 7'd0,
                              F_NONE));
    send_conversion(make_conv(64'hffff_0000_0000_7fff, MODE_16, 1'b0, 6'd0, 1'b0, 7'd0,
                              F_SPACE));
    send_conversion(make_conv(64'h0000_0001_8000_0000, MODE_32, 1'b0, 6'd0, 1'b0, 7'd0,
                              F_NONE));
    send_conversion(make_conv(64'hffff_ffff_7fff_ffff, MODE_32, 1'b0, 6'd0, 1'b0, 7'd0,
                              F_NONE));
    wait_text_drained();
    send_conversion(make_conv(64'd42, MODE_64, 1'b0, 6'd0, 1'b0, 7'd0, F_SPACE));
    send_conversion(make_conv(64'd42, MODE_64, 1'b0, 6'd0, 1'b0, 7'd0, F_PLUS | F_SPACE));
    send_conversion(make_conv(-64'd42, MODE_64, 1'b0, 6'd0, 1'b0, 7'd0, F_PLUS | F_SPACE));
    send_conversion(make_conv(64'd123, MODE_32, 1'b1, 6'd10, 1'b0, 7'd0, F_NONE));
    // longest text: sign plus 63 digits
    send_conversion(make_conv(-64'd5, MODE_64, 1'b1, 6'd63, 1'b0, 7'd0, F_NONE));
    send_conversion(make_conv(-64'd77, MODE_16, 1'b0, 6'd0, 1'b1, 7'd10, F_NONE));
    send_conversion(make_conv(-64'd77, MODE_16, 1'b0, 6'd0, 1'b1, 7'd10, F_LEFT));
    send_conversion(make_conv(-64'd77, MODE_16, 1'b0, 6'd0, 1'b1, 7'd10, F_ZERO));
    // zero fill wins over precision and over left justify
    send_conversion(make_conv(64'd9, MODE_8, 1'b1, 6'd3, 1'b1, 7'd10,
                              F_ZERO | F_LEFT | F_SPACE));
    // zero/left flags are inert without a width
    send_conversion(make_conv(64'd31, MODE_8, 1'b0, 6'd0, 1'b0, 7'd20, F_ZERO | F_LEFT));
    // width beyond the cap is clamped
    send_conversion(make_conv(64'd7, MODE_64, 1'b0, 6'd0, 1'b1, 7'd127, F_NONE));
    send_conversion(make_conv(-64'd1, MODE_64, 1'b0, 6'd0, 1'b1, 7'd64, F_LEFT));
    send_conversion(make_conv(64'd123456, MODE_32, 1'b0, 6'd0, 1'b1, 7'd3, F_ZERO));
    send_conversion(make_conv(64'd5, MODE_32, 1'b1, 6'd4, 1'b1, 7'd4, F_ZERO | F_PLUS));
  endtask

  task automatic test_random(input int count);
    repeat (count) begin
      if ($urandom_range(15) == 0) wait_text_drained();
      send_conversion(random_conv());
    end
  endtask

  initial begin
    do_reset();

    send_idle_pct = 36;
    recv_idle_pct = 65;
    test_directed();
    test_random(30);

    send_idle_pct = 65;
    recv_idle_pct = 36;
    test_random(25);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(20);

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d conversions (all widths, flags, precision and padding cases),",
             convs_sent);
    $display("checked %0d character beats under varied back-pressure, %0d errors.",
             chars_checked, error_count);
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
